@@ design/lph_pkg.sv @@
// Shared codes and the hash step for the linear probing hash table.
package lph_pkg;

    localparam int KEY_W = 64;
    localparam int LEN_W = 4;
    localparam int PUT_W = 32;
    localparam int CNT_W = 5;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 2;
    localparam int RES_W = STATUS_W + 1 + PUT_W + CNT_W;

    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 5'd8;

    // One byte of the one-at-a-time mix: (h + b) * 1025, then fold right by 6
    function automatic logic [KEY_W-1:0] oaat_step(input logic [KEY_W-1:0] h,
                                                   input logic [7:0] b);
        logic [KEY_W-1:0] bx;
        logic [KEY_W-1:0] t;
        bx = {{(KEY_W-8){b[7]}}, b};
        t = h + bx + (h << 10) + (bx << 10);
        return t ^ (t >> 6);
    endfunction

endpackage

@@ design/lph_fifo.sv @@
// Small first-in first-out queue used between the front, the back and the result port.
module lph_fifo #(
    parameter int W = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [W-1:0]      store_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              do_push;
    logic              do_pop;

    assign full = (fill_reg == FILL_W'(DEPTH));
    assign empty = (fill_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_data = store_reg[rd_ptr_reg];

    // Hold payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

@@ design/lph_front.sv @@
// Front end: takes requests, normalizes the key and hashes it to a home slot.
module lph_front
    import lph_pkg::*;
#(
    parameter int KEY_BYTES = 8,
    parameter int VALUE_WIDTH = 32,
    parameter int IW = 4,
    parameter int QW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              busy,
    input  logic [CMD_W-1:0]  command,
    input  logic [KEY_W-1:0]  key_bytes,
    input  logic [LEN_W-1:0]  key_length,
    input  logic [PUT_W-1:0]  put_value,
    output logic              q_push,
    output logic [QW-1:0]     q_data,
    input  logic              q_full
);
    localparam int KW = 8 * KEY_BYTES;

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_FIN, F_PUSH} fstate_t;

    fstate_t            state_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [KW-1:0]      key_reg;
    logic [KW-1:0]      shift_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [KEY_W-1:0]   hash_reg;
    logic [IW-1:0]      idx_reg;

    logic [LEN_W-1:0]   len_sat;
    logic [KEY_W-1:0]   key_masked;
    logic [63:0]        val_wide;
    logic [KEY_W-1:0]   fin_sum;
    logic [KEY_W-1:0]   fin_mix;

    assign busy = (state_reg != F_IDLE);

    // Saturate the length and clear bytes beyond it
    always_comb
    begin
        len_sat = (key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : key_length;
        for (int i = 0; i < 8; i++)
        begin
            key_masked[8*i +: 8] = (LEN_W'(i) < len_sat) ? key_bytes[8*i +: 8] : 8'd0;
        end
    end

    assign val_wide = 64'(put_value);

    // Final avalanche; only the low bits survive the slot mask
    assign fin_sum = hash_reg + (hash_reg << 3);
    assign fin_mix = fin_sum ^ (fin_sum >> 11);

    assign q_push = (state_reg == F_PUSH);
    assign q_data = {cmd_reg, key_reg, len_reg, val_reg, idx_reg};

    // Hold request payload
    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && push)
        begin
            cmd_reg <= command;
            key_reg <= key_masked[KW-1:0];
            shift_reg <= key_masked[KW-1:0];
            len_reg <= len_sat;
            rem_reg <= len_sat;
            val_reg <= val_wide[VALUE_WIDTH-1:0];
            hash_reg <= '0;
        end
        else if (state_reg == F_HASH)
        begin
            hash_reg <= oaat_step(hash_reg, shift_reg[7:0]);
            shift_reg <= shift_reg >> 8;
            rem_reg <= rem_reg - 1'b1;
        end
        if (state_reg == F_FIN)
        begin
            idx_reg <= fin_mix[IW-1:0];
        end
    end

    // Sequence: accept, hash one byte a cycle, finish, hand off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        state_reg <= (len_sat == '0) ? F_FIN : F_HASH;
                    end
                end
                F_HASH:
                begin
                    if (rem_reg == LEN_W'(1))
                    begin
                        state_reg <= F_FIN;
                    end
                end
                F_FIN:
                begin
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/lph_back.sv @@
// Back end: probes the slot memories, applies the command and builds the result.
module lph_back
    import lph_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BYTES = 8,
    parameter int VALUE_WIDTH = 32,
    parameter int IW = 4,
    parameter int QW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  max_entries,
    output logic              clearing,
    input  logic              q_empty,
    input  logic [QW-1:0]     q_data,
    output logic              q_pop,
    output logic              r_push,
    output logic [RES_W-1:0]  r_data,
    input  logic              r_full
);
    localparam int KW = 8 * KEY_BYTES;
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_READ, B_CHECK, B_EXEC, B_OUT} bstate_t;

    // Slot memories
    logic [1:0]             state_mem [CAPACITY];
    logic [KW-1:0]          key_mem   [CAPACITY];
    logic [LEN_W-1:0]       len_mem   [CAPACITY];
    logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];

    logic [1:0]             rd_state_reg;
    logic [KW-1:0]          rd_key_reg;
    logic [LEN_W-1:0]       rd_len_reg;
    logic [VALUE_WIDTH-1:0] rd_value_reg;

    bstate_t                bstate_reg;
    logic [IW-1:0]          clr_idx_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [KW-1:0]          key_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [IW-1:0]          idx_reg;
    logic [IW:0]            probe_n_reg;
    logic                   tomb_vld_reg;
    logic [IW-1:0]          tomb_idx_reg;
    logic                   hit_reg;
    logic                   free_ok_reg;
    logic [IW-1:0]          slot_reg;
    logic [VALUE_WIDTH-1:0] hit_value_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic                   found_reg;
    logic [PUT_W-1:0]       rdval_reg;

    logic [CMD_W-1:0]       q_cmd;
    logic [KW-1:0]          q_key;
    logic [LEN_W-1:0]       q_len;
    logic [VALUE_WIDTH-1:0] q_val;
    logic [IW-1:0]          q_idx;

    logic                   is_put;
    logic                   is_remove;
    logic                   put_new;
    logic                   tomb_now;
    logic                   tv_now;
    logic [IW-1:0]          ti_now;
    logic                   key_match;
    logic                   last_probe;
    logic                   st_we;
    logic [IW-1:0]          st_waddr;
    logic [1:0]             st_wdata;
    logic                   new_we;
    logic                   val_we;
    logic [63:0]            hit_wide;

    assign {q_cmd, q_key, q_len, q_val, q_idx} = q_data;

    assign clearing = (bstate_reg == B_CLEAR);
    assign q_pop = (bstate_reg == B_IDLE) && !q_empty;
    assign r_push = (bstate_reg == B_OUT);
    assign r_data = {status_reg, found_reg, rdval_reg, count_reg};

    assign is_put = (cmd_reg == CMD_PUT);
    assign is_remove = (cmd_reg == CMD_REMOVE);
    assign put_new = !hit_reg && (count_reg < max_entries) && free_ok_reg;

    // Classify the slot just read
    assign tomb_now = (rd_state_reg == ST_TOMB);
    assign tv_now = tomb_vld_reg || tomb_now;
    assign ti_now = tomb_vld_reg ? tomb_idx_reg : idx_reg;
    assign key_match = (rd_state_reg == ST_LIVE) && (rd_len_reg == len_reg)
                       && (rd_key_reg == key_reg);
    assign last_probe = (probe_n_reg == (IW+1)'(CAPACITY - 1));

    // Memory write controls
    always_comb
    begin
        st_we = 1'b0;
        st_waddr = slot_reg;
        st_wdata = ST_EMPTY;
        new_we = 1'b0;
        val_we = 1'b0;
        if (bstate_reg == B_CLEAR)
        begin
            st_we = 1'b1;
            st_waddr = clr_idx_reg;
        end
        else if (bstate_reg == B_EXEC)
        begin
            if (is_put && put_new)
            begin
                st_we = 1'b1;
                st_wdata = ST_LIVE;
                new_we = 1'b1;
                val_we = 1'b1;
            end
            else if (is_put && hit_reg)
            begin
                val_we = 1'b1;
            end
            else if (is_remove && hit_reg)
            begin
                st_we = 1'b1;
                st_wdata = ST_TOMB;
            end
        end
    end

    // Write and read the slot memories
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            state_mem[st_waddr] <= st_wdata;
        end
        if (new_we)
        begin
            key_mem[slot_reg] <= key_reg;
            len_mem[slot_reg] <= len_reg;
        end
        if (val_we)
        begin
            value_mem[slot_reg] <= val_reg;
        end
        rd_state_reg <= state_mem[idx_reg];
        rd_key_reg <= key_mem[idx_reg];
        rd_len_reg <= len_mem[idx_reg];
        rd_value_reg <= value_mem[idx_reg];
    end

    assign hit_wide = 64'(hit_value_reg);

    // Hold request fields
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
            key_reg <= q_key;
            len_reg <= q_len;
            val_reg <= q_val;
        end
        if (bstate_reg == B_CHECK && key_match)
        begin
            hit_value_reg <= rd_value_reg;
        end
    end

    // Sequence: clear, fetch, probe, apply, deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg <= B_CLEAR;
            clr_idx_reg <= '0;
            idx_reg <= '0;
            probe_n_reg <= '0;
            tomb_vld_reg <= 1'b0;
            tomb_idx_reg <= '0;
            hit_reg <= 1'b0;
            free_ok_reg <= 1'b0;
            slot_reg <= '0;
            count_reg <= '0;
            status_reg <= STATUS_ABSENT;
            found_reg <= 1'b0;
            rdval_reg <= '0;
        end
        else
        begin
            case (bstate_reg)
                B_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                    if (clr_idx_reg == IW'(CAPACITY - 1))
                    begin
                        bstate_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        idx_reg <= q_idx;
                        probe_n_reg <= '0;
                        tomb_vld_reg <= 1'b0;
                        bstate_reg <= B_READ;
                    end
                end
                B_READ:
                begin
                    bstate_reg <= B_CHECK;
                end
                B_CHECK:
                begin
                    tomb_vld_reg <= tv_now;
                    tomb_idx_reg <= ti_now;
                    if (rd_state_reg == ST_EMPTY)
                    begin
                        hit_reg <= 1'b0;
                        free_ok_reg <= 1'b1;
                        slot_reg <= ti_now;
                        bstate_reg <= B_EXEC;
                    end
                    else if (key_match)
                    begin
                        hit_reg <= 1'b1;
                        slot_reg <= idx_reg;
                        bstate_reg <= B_EXEC;
                    end
                    else if (last_probe)
                    begin
                        hit_reg <= 1'b0;
                        free_ok_reg <= tv_now;
                        slot_reg <= ti_now;
                        bstate_reg <= B_EXEC;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        probe_n_reg <= probe_n_reg + 1'b1;
                        bstate_reg <= B_READ;
                    end
                end
                B_EXEC:
                begin
                    found_reg <= hit_reg;
                    rdval_reg <= '0;
                    status_reg <= STATUS_ABSENT;
                    if (is_put)
                    begin
                        if (hit_reg)
                        begin
                            status_reg <= STATUS_DONE;
                        end
                        else if (put_new)
                        begin
                            status_reg <= STATUS_DONE;
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            status_reg <= STATUS_FULL;
                        end
                    end
                    else if (is_remove)
                    begin
                        if (hit_reg)
                        begin
                            status_reg <= STATUS_DONE;
                            count_reg <= count_reg - 1'b1;
                        end
                    end
                    else if (hit_reg)
                    begin
                        status_reg <= STATUS_DONE;
                        rdval_reg <= hit_wide[PUT_W-1:0];
                    end
                    bstate_reg <= B_OUT;
                end
                B_OUT:
                begin
                    if (!r_full)
                    begin
                        bstate_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    bstate_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/linear_probe_hash_table.sv @@
// Flow: the front hashes the key, then the back probes from the home slot (1 to CAPACITY
// slots are read and checked in turn), applies the command and delivers the result.
// Hashing of the next item overlaps the current probe through a 2-entry queue.
// Reset: asynchronous, clears the live count and sets max_entries to 8, then a clearing
// pass marks every slot empty; no item is taken during it.
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int KEY_BYTES = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [CMD_W-1:0]     command,
    input  logic [KEY_W-1:0]     key_bytes,
    input  logic [LEN_W-1:0]     key_length,
    input  logic [PUT_W-1:0]     put_value,
    output logic                 empty,
    input  logic                 pop,
    output logic [STATUS_W-1:0]  status,
    output logic                 found,
    output logic [PUT_W-1:0]     read_value,
    output logic [CNT_W-1:0]     live_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CNT_W-1:0]     cfg_data
);
    localparam int IW = $clog2(CAPACITY);
    localparam int QW = CMD_W + 8 * KEY_BYTES + LEN_W + VALUE_WIDTH + IW;

    logic [CNT_W-1:0]  max_entries_reg;
    logic              front_busy;
    logic              clearing;
    logic              q_push;
    logic [QW-1:0]     q_in;
    logic              q_full;
    logic              q_pop;
    logic [QW-1:0]     q_out;
    logic              q_empty;
    logic              r_push;
    logic [RES_W-1:0]  r_in;
    logic              r_full;
    logic [RES_W-1:0]  r_out;

    assign cfg_ready = 1'b1;
    assign full = front_busy || clearing;

    // Hold the entry limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else if (cfg_valid)
        begin
            max_entries_reg <= cfg_data;
        end
    end

    lph_front #(
        .KEY_BYTES(KEY_BYTES), .VALUE_WIDTH(VALUE_WIDTH),
        .IW(IW), .QW(QW)
    ) u_front (
        .clk(clk), .rst_n(rst_n),
        .push(push && !clearing), .busy(front_busy),
        .command(command), .key_bytes(key_bytes), .key_length(key_length),
        .put_value(put_value),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    lph_fifo #(.W(QW), .DEPTH(2)) u_req_q (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .empty(q_empty)
    );

    lph_back #(
        .CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES), .VALUE_WIDTH(VALUE_WIDTH),
        .IW(IW), .QW(QW)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .max_entries(max_entries_reg), .clearing(clearing),
        .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
        .r_push(r_push), .r_data(r_in), .r_full(r_full)
    );

    lph_fifo #(.W(RES_W), .DEPTH(2)) u_res_q (
        .clk(clk), .rst_n(rst_n),
        .push(r_push), .push_data(r_in), .full(r_full),
        .pop(pop), .pop_data(r_out), .empty(empty)
    );

    assign {status, found, read_value, live_count} = r_out;

endmodule

@@ tb/linear_probe_hash_table_tb.sv @@
// Testbench for the linear probing hash table: directed and random requests against a predictor.
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
    import lph_pkg::*;

    localparam int SLOTS = 16;
    localparam int KEY_MAX = 8;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_SIZE = 24;

    typedef enum logic [1:0] {SLOT_EMPTY = 2'd0, SLOT_LIVE = 2'd1, SLOT_TOMB = 2'd2} slot_kind_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [PUT_W-1:0]    read_value;
        logic [CNT_W-1:0]    live_count;
    } reply_t;

    logic                clk;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [CMD_W-1:0]    command;
    logic [KEY_W-1:0]    key_bytes;
    logic [LEN_W-1:0]    key_length;
    logic [PUT_W-1:0]    put_value;
    logic                empty;
    logic                pop;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [PUT_W-1:0]    read_value;
    logic [CNT_W-1:0]    live_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CNT_W-1:0]    cfg_data;

    // Shadow copy of the table
    slot_kind_t          tbl_kind [SLOTS];
    logic [KEY_W-1:0]    tbl_key [SLOTS];
    logic [LEN_W-1:0]    tbl_len [SLOTS];
    logic [PUT_W-1:0]    tbl_val [SLOTS];
    logic [CNT_W-1:0]    tbl_count;
    logic [CNT_W-1:0]    tbl_limit;

    reply_t              pending_replies [$];
    logic [KEY_W-1:0]    pool_key [POOL_SIZE];
    logic [LEN_W-1:0]    pool_len [POOL_SIZE];
    int                  errors;
    int                  cycles;
    int                  burst_left;
    logic [15:0]         stall_pattern;

    linear_probe_hash_table uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .key_bytes  (key_bytes),
        .key_length (key_length),
        .put_value  (put_value),
        .empty      (empty),
        .pop        (pop),
        .status     (status),
        .found      (found),
        .read_value (read_value),
        .live_count (live_count),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One-at-a-time hash over the sign-extended key bytes
    function automatic logic [KEY_W-1:0] key_hash(input logic [KEY_W-1:0] k, input int n);
        logic [KEY_W-1:0] h;
        logic [KEY_W-1:0] b;
        h = '0;
        for (int i = 0; i < n; i++)
        begin
            b = {{56{k[8*i+7]}}, k[8*i +: 8]};
            h = h + b;
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    // Apply one request to the shadow table and return its reply
    function automatic reply_t apply_request(input logic [CMD_W-1:0] cmd,
                                             input logic [KEY_W-1:0] kin,
                                             input logic [LEN_W-1:0] lin,
                                             input logic [PUT_W-1:0] v);
        reply_t r;
        int n;
        int s;
        int hit;
        int tomb;
        int freeslot;
        logic [KEY_W-1:0] k;
        n = (lin > KEY_MAX) ? KEY_MAX : lin;
        k = (n >= 8) ? kin : (kin & ((64'd1 << (8 * n)) - 64'd1));
        s = int'(key_hash(k, n) & 64'(SLOTS - 1));
        hit = -1;
        tomb = -1;
        freeslot = -1;
        for (int p = 0; p < SLOTS; p++)
        begin
            if (tbl_kind[s] == SLOT_TOMB)
            begin
                if (tomb < 0)
                    tomb = s;
            end
            else if (tbl_kind[s] == SLOT_EMPTY)
            begin
                freeslot = (tomb >= 0) ? tomb : s;
                break;
            end
            else if (tbl_len[s] == n && tbl_key[s] == k)
            begin
                hit = s;
                break;
            end
            s = (s + 1) & (SLOTS - 1);
            if (p == SLOTS - 1)
                freeslot = tomb;
        end
        r.status = STATUS_ABSENT;
        r.found = (hit >= 0);
        r.read_value = '0;
        if (cmd == CMD_PUT)
        begin
            if (hit >= 0)
            begin
                tbl_val[hit] = v;
                r.status = STATUS_DONE;
            end
            else if (tbl_count >= tbl_limit || freeslot < 0)
                r.status = STATUS_FULL;
            else
            begin
                tbl_kind[freeslot] = SLOT_LIVE;
                tbl_key[freeslot] = k;
                tbl_len[freeslot] = LEN_W'(n);
                tbl_val[freeslot] = v;
                tbl_count = tbl_count + 1'b1;
                r.status = STATUS_DONE;
            end
        end
        else if (cmd == CMD_REMOVE)
        begin
            if (hit >= 0)
            begin
                tbl_kind[hit] = SLOT_TOMB;
                tbl_count = tbl_count - 1'b1;
                r.status = STATUS_DONE;
            end
        end
        else if (hit >= 0)
        begin
            r.read_value = tbl_val[hit];
            r.status = STATUS_DONE;
        end
        r.live_count = tbl_count;
        return r;
    endfunction

    // Send one item, with burst gaps, and hold until it is taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] k,
                             input logic [LEN_W-1:0] n, input logic [PUT_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        command <= cmd;
        key_bytes <= k;
        key_length <= n;
        put_value <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_replies.push_back(apply_request(cmd, k, n, v));
    endtask

    // Drain, let the block settle, then write max_entries
    task automatic write_max_entries(input logic [CNT_W-1:0] m);
        push <= 1'b0;
        burst_left = 0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tbl_limit = m;
    endtask

    // Pool key with random noise above its length
    task automatic send_pool(input logic [CMD_W-1:0] cmd, input int i);
        logic [KEY_W-1:0] noise;
        logic [KEY_W-1:0] keep;
        noise = {$urandom, $urandom};
        keep = (pool_len[i] >= 8) ? '1 : ((64'd1 << (8 * pool_len[i])) - 64'd1);
        send_item(cmd, (pool_key[i] & keep) | (noise & ~keep), pool_len[i], $urandom);
    endtask

    task automatic test_directed();
        write_max_entries(5'd2);
        send_item(CMD_GET, 64'h0, 4'd0, 32'h0);
        send_item(CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'hFFFF_FFFF);
        send_item(CMD_GET, 64'h1234, 4'd0, 32'h0);
        send_item(CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'hA5A5_5A5A);
        send_item(CMD_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        // table at or above its limit: new key refused, overwrite allowed
        send_item(CMD_PUT, 64'h80, 4'd1, 32'h1);
        send_item(CMD_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        send_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'h0);
        send_item(CMD_REMOVE, 64'h7F, 4'd1, 32'h0);
        send_item(CMD_REMOVE, 64'h0, 4'd0, 32'h0);
        send_item(CMD_GET, 64'h0, 4'd0, 32'h0);
        send_item(CMD_PUT, 64'h80, 4'd1, 32'h5);
        send_item(CMD_GET, 64'hFF80, 4'd1, 32'h0);
        write_max_entries(5'd0);
        send_item(CMD_PUT, 64'h55, 4'd1, 32'h7);
        send_item(CMD_PUT, 64'h80, 4'd1, 32'h9);
        send_item(CMD_REMOVE, 64'h80, 4'd1, 32'h0);
        send_item(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'h0);
    endtask

    // Mostly pool keys so that hits, tombstones and full tables occur
    task automatic test_random_mix(input logic [CNT_W-1:0] m, input int count, input int put_bias);
        int r;
        write_max_entries(m);
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 8)
                send_pool((r < put_bias) ? CMD_PUT : ((r < put_bias + 25) ? CMD_REMOVE :
                          ((r < 97) ? CMD_GET : CMD_UNUSED)), $urandom_range(0, POOL_SIZE - 1));
            else
                send_item(CMD_W'($urandom_range(0, 3)), {$urandom, $urandom},
                          LEN_W'($urandom_range(0, 15)), $urandom);
        end
    endtask

    // Result checker and receiver stall pattern
    always @(posedge clk)
    begin
        reply_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_replies.size() == 0)
                begin
                    $display("%0t: unexpected result status=%0d", $time, status);
                    errors++;
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                        errors++;
                    end
                    if (found !== want.found)
                    begin
                        $display("%0t: found expected %0d actual %0d", $time, want.found, found);
                        errors++;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $display("%0t: read_value expected %h actual %h", $time,
                                 want.read_value, read_value);
                        errors++;
                    end
                    if (live_count !== want.live_count)
                    begin
                        $display("%0t: live_count expected %0d actual %0d", $time,
                                 want.live_count, live_count);
                        errors++;
                    end
                end
            end
            // Rotate the stall pattern; pick a new one now and then
            if ($urandom_range(0, 199) == 0)
                stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            else
                stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            pop <= stall_pattern[0];
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        burst_left = 0;
        stall_pattern = 16'hFFFF;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        command = '0;
        key_bytes = '0;
        key_length = '0;
        put_value = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_kind[i] = SLOT_EMPTY;
            tbl_key[i] = '0;
            tbl_len[i] = '0;
            tbl_val[i] = '0;
        end
        tbl_count = '0;
        tbl_limit = MAX_ENTRIES_RESET;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_key[i] = {$urandom, $urandom};
            pool_len[i] = LEN_W'((i < 2) ? i : $urandom_range(1, 8));
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_random_mix(MAX_ENTRIES_RESET, 40, 50);
        test_directed();
        test_random_mix(5'd16, 300, 50);
        test_random_mix(5'd1, 150, 45);
        test_random_mix(5'd31, 300, 60);
        test_random_mix(5'd5, 180, 40);
        test_random_mix(5'd12, 180, 50);

        // Wait out the last results
        push <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
